FILE: sv/bbqa_pkg.sv
// ----------------------------------------------------------------------------
// Byte budget queue admission package
// Shared widths, codes, sequencer states and the control and status bundles
// that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bbqa_pkg;

  localparam int DATA_W    = 24;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 4;
  localparam int OUT_CNT_W = 7;
  localparam int ADDR_W    = 4;
  localparam int PDATA_W   = 32;

  localparam logic [DATA_W-1:0] HIGH_WATER_RESET = DATA_W'(1024 * 1024);
  localparam logic [DATA_W-1:0] LOW_WATER_RESET  = DATA_W'(512 * 1024);

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE    = 3'd0,
    REQ_DEQUEUE    = 3'd1,
    REQ_SEND_FAIL  = 3'd2,
    REQ_DISCONNECT = 3'd3,
    REQ_START      = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    MODE_BLOCK      = 2'd0,
    MODE_DROP_NEW   = 2'd1,
    MODE_DROP_OLD   = 2'd2,
    MODE_DISCONNECT = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 4'd0,
    ST_TOO_LARGE = 4'd1,
    ST_RETRY     = 4'd2,
    ST_DROP_NEW  = 4'd3,
    ST_OVF_DISC  = 4'd4,
    ST_INACTIVE  = 4'd5,
    ST_DEQUEUED  = 4'd6,
    ST_EMPTY     = 4'd7,
    ST_DONE      = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_HIGH = 2'd1,
    REG_LOW  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_LEN,
    S_CHK_LW,
    S_CHK_OVF,
    S_READ,
    S_POP,
    S_ACC,
    S_LW_DEQ,
    S_PUSH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    A_ZERO,
    A_TOTAL,
    A_DROPB
  } a_sel_t;

  typedef enum logic [1:0] {
    B_ZERO,
    B_LEN,
    B_RDATA
  } b_sel_t;

  typedef enum logic {
    C_HW,
    C_LW
  } c_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    item_start;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    alu_sub;
    c_sel_t  c_sel;
    logic    mem_rd;
    logic    pop;
    logic    pop_deq;
    logic    acc_drop;
    logic    push;
    logic    lw_load;
    logic    st_load;
    status_t st_val;
    logic    act_clr;
    logic    act_set;
    logic    finish;
  } bbqa_ctrl_t;

  typedef struct packed {
    logic  in_valid;
    req_t  in_req;
    req_t  req_r;
    mode_t mode;
    logic  active;
    logic  count_zero;
    logic  full;
    logic  alu_gt;
    logic  out_free;
  } bbqa_stat_t;

endpackage

`default_nettype wire

FILE: sv/byte_budget_queue_admission.sv
// ----------------------------------------------------------------------------
// Byte budget queue admission
// Admission control for a transmit queue held as a FIFO of message lengths
// with a running byte total, watermarks and four overflow policies.
// ----------------------------------------------------------------------------
// in_ready is high only while the sequencer is idle. Link control requests
// (send failed, disconnect, start) and a dequeue on an empty queue go
// straight to the final state. An enqueue runs the length check, in block
// mode the low water check, and the overflow check, then is pushed unless
// refused; a dequeue reads, pops and checks the low water mark. In
// drop-oldest mode each discarded head adds a read, a pop and a drop tally.
// The steps follow from the single shared adder/comparator, which performs
// one add, subtract or watermark compare per cycle, and from the registered
// read port of the length memory, read in its own state before each pop.
// The result of a request is held in an output register, so the next request
// is taken while the previous result still waits on out_ready; the block only
// stalls in its final state when a second result would overwrite one not yet
// taken. The length memory is not cleared after reset: every read is guarded
// by the entry count, so no clearing pass is needed. Configuration must be
// written through the APB port (mode at 0x0, high water at 0x4, low water at
// 0x8) only while no request is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_budget_queue_admission
  import bbqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [DATA_W-1:0]    in_msg_len,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [DATA_W-1:0]         out_dequeued_len,
  output logic [OUT_CNT_W-1:0]      out_dropped_entries,
  output logic [DATA_W-1:0]         out_dropped_bytes,
  output logic                      out_wake_sender,
  output logic                      out_below_low_water,
  output logic [DATA_W-1:0]         out_bytes_queued,
  output logic [OUT_CNT_W-1:0]      out_entries_queued,
  output logic                      out_link_active,

  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  // Configuration registers.
  mode_t             mode_r;
  logic [DATA_W-1:0] high_water_r;
  logic [DATA_W-1:0] low_water_r;

  // Queue state.
  logic [DATA_W-1:0] fifo_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [DATA_W-1:0] total_r;
  logic              active_r;

  // Per-request working registers.
  req_t              req_r;
  logic [DATA_W-1:0] len_r;
  logic [DATA_W-1:0] rdata_r;
  status_t           status_r;
  logic [DATA_W-1:0] deq_len_r;
  logic [CNT_W-1:0]  drop_n_r;
  logic [DATA_W-1:0] drop_b_r;
  logic              wake_r;
  logic              below_r;

  // Output register.
  logic              out_valid_r;
  status_t           o_status_r;
  logic [DATA_W-1:0] o_deq_len_r;
  logic [CNT_W-1:0]  o_drop_n_r;
  logic [DATA_W-1:0] o_drop_b_r;
  logic              o_wake_r;
  logic              o_below_r;
  logic [DATA_W-1:0] o_total_r;
  logic [CNT_W-1:0]  o_count_r;
  logic              o_active_r;

  bbqa_ctrl_t        ctrl;
  bbqa_stat_t        stat;
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic [DATA_W-1:0] alu_c;
  logic [DATA_W:0]   alu_res;
  logic              alu_gt;
  logic              cfg_wr;
  logic              q_full;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;

  // --------------------------------------------------------------------------
  // APB configuration port. Writes land in the access phase; reads are
  // returned combinationally, so pready is tied high.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BLOCK;
      high_water_r <= HIGH_WATER_RESET;
      low_water_r  <= LOW_WATER_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(paddr[3:2]))
        REG_MODE: mode_r       <= mode_t'(pwdata[1:0]);
        REG_HIGH: high_water_r <= pwdata[DATA_W-1:0];
        REG_LOW:  low_water_r  <= pwdata[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_t'(paddr[3:2]))
      REG_MODE: prdata = PDATA_W'(mode_r);
      REG_HIGH: prdata = PDATA_W'(high_water_r);
      REG_LOW:  prdata = PDATA_W'(low_water_r);
      default:  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and shared arithmetic unit. The sequencer picks the operands;
  // every watermark check, byte-total update and drop tally goes through the
  // one adder/comparator.
  // --------------------------------------------------------------------------
  assign q_full = (count_r == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    stat.in_valid   = in_valid;
    stat.in_req     = req_t'(in_req_type);
    stat.req_r      = req_r;
    stat.mode       = mode_r;
    stat.active     = active_r;
    stat.count_zero = (count_r == '0);
    stat.full       = q_full;
    stat.alu_gt     = alu_gt;
    stat.out_free   = !out_valid_r || out_ready;
  end

  bbqa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  always_comb begin
    case (ctrl.a_sel)
      A_TOTAL: alu_a = total_r;
      A_DROPB: alu_a = drop_b_r;
      default: alu_a = '0;
    endcase
    case (ctrl.b_sel)
      B_LEN:   alu_b = len_r;
      B_RDATA: alu_b = rdata_r;
      default: alu_b = '0;
    endcase
    alu_c = (ctrl.c_sel == C_LW) ? low_water_r : high_water_r;
  end

  bbqa_alu u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .sub   (ctrl.alu_sub),
    .limit (alu_c),
    .res   (alu_res),
    .gt    (alu_gt)
  );

  // --------------------------------------------------------------------------
  // Queue state. Pointers wrap at the queue depth, which need not be a power
  // of two. A pop whose length exceeds the running total clamps it at zero.
  // --------------------------------------------------------------------------
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      total_r  <= '0;
      active_r <= 1'b0;
    end else begin
      if (ctrl.act_clr) begin
        active_r <= 1'b0;
      end else if (ctrl.act_set) begin
        active_r <= 1'b1;
      end
      if (ctrl.pop) begin
        head_r  <= head_inc;
        count_r <= count_r - CNT_W'(1);
        total_r <= alu_res[DATA_W] ? '0 : alu_res[DATA_W-1:0];
      end else if (ctrl.push) begin
        tail_r  <= tail_inc;
        count_r <= count_r + CNT_W'(1);
        total_r <= alu_res[DATA_W-1:0];
      end
    end
  end

  // Length memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      fifo_mem[tail_r] <= len_r;
    end
    if (ctrl.mem_rd) begin
      rdata_r <= fifo_mem[head_r];
    end
  end

  // Per-request result fields, cleared when a new request is taken.
  always_ff @(posedge clk) begin
    if (ctrl.item_start) begin
      req_r     <= req_t'(in_req_type);
      len_r     <= in_msg_len;
      deq_len_r <= '0;
      drop_n_r  <= '0;
      drop_b_r  <= '0;
      wake_r    <= 1'b0;
      below_r   <= 1'b0;
    end else begin
      if (ctrl.pop && ctrl.pop_deq) begin
        deq_len_r <= rdata_r;
      end
      if (ctrl.pop && !ctrl.pop_deq) begin
        drop_n_r <= drop_n_r + CNT_W'(1);
      end
      if (ctrl.acc_drop) begin
        drop_b_r <= alu_res[DATA_W-1:0];
      end
      if (ctrl.push) begin
        wake_r <= (count_r == '0);
      end
      if (ctrl.lw_load) begin
        below_r <= !alu_gt;
      end
    end
    if (ctrl.st_load) begin
      status_r <= ctrl.st_val;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It is loaded only when empty or being drained, so a
  // finished result is never overwritten.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      o_status_r  <= status_r;
      o_deq_len_r <= deq_len_r;
      o_drop_n_r  <= drop_n_r;
      o_drop_b_r  <= drop_b_r;
      o_wake_r    <= wake_r;
      o_below_r   <= below_r;
      o_total_r   <= total_r;
      o_count_r   <= count_r;
      o_active_r  <= active_r;
    end
  end

  assign in_ready            = ctrl.in_ready;
  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_dequeued_len    = o_deq_len_r;
  assign out_dropped_entries = OUT_CNT_W'(o_drop_n_r);
  assign out_dropped_bytes   = o_drop_b_r;
  assign out_wake_sender     = o_wake_r;
  assign out_below_low_water = o_below_r;
  assign out_bytes_queued    = o_total_r;
  assign out_entries_queued  = OUT_CNT_W'(o_count_r);
  assign out_link_active     = o_active_r;

  // --------------------------------------------------------------------------
  // Checks on the queue bookkeeping.
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds the queue depth");

  a_empty_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("empty queue holds a nonzero byte total");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !q_full)
    else $error("push into a full queue");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.item_start |=> !ctrl.in_ready)
    else $error("new request taken while one is in progress");

endmodule

`default_nettype wire

FILE: sv/bbqa_alu.sv
// ----------------------------------------------------------------------------
// Shared add/subtract and compare unit
// Adds or subtracts two byte counts and compares the result with a watermark.
// ----------------------------------------------------------------------------
`default_nettype none

module bbqa_alu
  import bbqa_pkg::*;
(
  input  wire logic [DATA_W-1:0] op_a,
  input  wire logic [DATA_W-1:0] op_b,
  input  wire logic              sub,
  input  wire logic [DATA_W-1:0] limit,
  output logic      [DATA_W:0]   res,
  output logic                   gt
);

  // One extra bit holds the carry of an add or the borrow of a subtract.
  always_comb begin
    if (sub) begin
      res = {1'b0, op_a} - {1'b0, op_b};
    end else begin
      res = {1'b0, op_a} + {1'b0, op_b};
    end
    gt = (res > {1'b0, limit});
  end

endmodule

`default_nettype wire

FILE: sv/bbqa_seq.sv
// ----------------------------------------------------------------------------
// Admission sequencer
// Steps one request through the checks, pops and pushes, driving the shared
// arithmetic unit and the queue datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bbqa_seq
  import bbqa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bbqa_stat_t stat,
  output bbqa_ctrl_t      ctrl
);

  state_t state_r;
  state_t state_nxt;
  logic   ovf;

  assign ovf = stat.alu_gt || stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) begin
          case (stat.in_req)
            REQ_ENQUEUE: state_nxt = S_CHK_LEN;
            REQ_DEQUEUE: state_nxt = stat.count_zero ? S_DONE : S_READ;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_CHK_LEN: begin
        if (!stat.active || stat.alu_gt) begin
          state_nxt = S_DONE;
        end else if (stat.mode == MODE_BLOCK) begin
          state_nxt = S_CHK_LW;
        end else begin
          state_nxt = S_CHK_OVF;
        end
      end
      S_CHK_LW: begin
        state_nxt = stat.alu_gt ? S_DONE : S_CHK_OVF;
      end
      S_CHK_OVF: begin
        if (!ovf) begin
          state_nxt = S_PUSH;
        end else if (stat.mode == MODE_DROP_OLD) begin
          state_nxt = stat.count_zero ? S_PUSH : S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ:   state_nxt = S_POP;
      S_POP:    state_nxt = (stat.req_r == REQ_DEQUEUE) ? S_LW_DEQ : S_ACC;
      S_ACC:    state_nxt = S_CHK_OVF;
      S_LW_DEQ: state_nxt = S_DONE;
      S_PUSH:   state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready   = 1'b0;
    ctrl.item_start = 1'b0;
    ctrl.a_sel      = A_ZERO;
    ctrl.b_sel      = B_ZERO;
    ctrl.alu_sub    = 1'b0;
    ctrl.c_sel      = C_HW;
    ctrl.mem_rd     = 1'b0;
    ctrl.pop        = 1'b0;
    ctrl.pop_deq    = 1'b0;
    ctrl.acc_drop   = 1'b0;
    ctrl.push       = 1'b0;
    ctrl.lw_load    = 1'b0;
    ctrl.st_load    = 1'b0;
    ctrl.st_val     = ST_DONE;
    ctrl.act_clr    = 1'b0;
    ctrl.act_set    = 1'b0;
    ctrl.finish     = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (stat.in_valid) begin
          ctrl.item_start = 1'b1;
          case (stat.in_req)
            REQ_ENQUEUE: begin
            end
            REQ_DEQUEUE: begin
              ctrl.st_load = stat.count_zero;
              ctrl.st_val  = ST_EMPTY;
            end
            REQ_SEND_FAIL, REQ_DISCONNECT: begin
              ctrl.act_clr = 1'b1;
              ctrl.st_load = 1'b1;
            end
            REQ_START: begin
              ctrl.act_set = 1'b1;
              ctrl.st_load = 1'b1;
            end
            default: begin
              ctrl.st_load = 1'b1;
            end
          endcase
        end
      end
      S_CHK_LEN: begin
        ctrl.b_sel = B_LEN;
        if (!stat.active) begin
          ctrl.st_load = 1'b1;
          ctrl.st_val  = ST_INACTIVE;
        end else if (stat.alu_gt) begin
          ctrl.st_load = 1'b1;
          ctrl.st_val  = ST_TOO_LARGE;
        end
      end
      S_CHK_LW: begin
        ctrl.a_sel   = A_TOTAL;
        ctrl.c_sel   = C_LW;
        ctrl.st_load = stat.alu_gt;
        ctrl.st_val  = ST_RETRY;
      end
      S_CHK_OVF: begin
        ctrl.a_sel = A_TOTAL;
        ctrl.b_sel = B_LEN;
        if (ovf) begin
          case (stat.mode)
            MODE_BLOCK: begin
              ctrl.st_load = 1'b1;
              ctrl.st_val  = ST_RETRY;
            end
            MODE_DROP_NEW: begin
              ctrl.st_load = 1'b1;
              ctrl.st_val  = ST_DROP_NEW;
            end
            MODE_DROP_OLD: begin
            end
            MODE_DISCONNECT: begin
              ctrl.act_clr = 1'b1;
              ctrl.st_load = 1'b1;
              ctrl.st_val  = ST_OVF_DISC;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        ctrl.mem_rd = 1'b1;
      end
      S_POP: begin
        ctrl.a_sel   = A_TOTAL;
        ctrl.b_sel   = B_RDATA;
        ctrl.alu_sub = 1'b1;
        ctrl.pop     = 1'b1;
        ctrl.pop_deq = (stat.req_r == REQ_DEQUEUE);
      end
      S_ACC: begin
        ctrl.a_sel    = A_DROPB;
        ctrl.b_sel    = B_RDATA;
        ctrl.acc_drop = 1'b1;
      end
      S_LW_DEQ: begin
        ctrl.a_sel   = A_TOTAL;
        ctrl.c_sel   = C_LW;
        ctrl.lw_load = 1'b1;
        ctrl.st_load = 1'b1;
        ctrl.st_val  = ST_DEQUEUED;
      end
      S_PUSH: begin
        ctrl.a_sel   = A_TOTAL;
        ctrl.b_sel   = B_LEN;
        ctrl.push    = 1'b1;
        ctrl.st_load = 1'b1;
        ctrl.st_val  = ST_ACCEPTED;
      end
      S_DONE: begin
        ctrl.finish = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
